// ===== sv/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// spa_pkg: shared definitions for the sinusoid phasor adder
// Widths, CORDIC constants and the record types that travel down the pipeline.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int PHASE_BITS    = 16;

  // Component width: magnitudes stay below 2^49 through every stage.
  localparam int CW = 52;

  localparam logic [31:0] GAIN_Q32     = 32'd2608131496;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [31:0] ATAN_TABLE [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // One phasor in flight: components and residual angle.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cvec_t;

  // Side information that rides along with each item.
  typedef struct packed {
    logic        mism;
    logic [31:0] freq;
    logic        zero;
  } side_t;

endpackage

// ===== sv/spa_in_if.sv =====
// ----------------------------------------------------------------------------
// spa_in_if: input channel of the phasor adder
// Valid/ready channel carrying the operation and both sinusoids.
// ----------------------------------------------------------------------------
interface spa_in_if import spa_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [31:0]           amplitude_a;
  logic signed [31:0]           frequency_a;
  logic signed [PHASE_BITS-1:0] phase_a;
  logic signed [31:0]           amplitude_b;
  logic signed [31:0]           frequency_b;
  logic signed [PHASE_BITS-1:0] phase_b;

  modport source (output valid, operation, amplitude_a, frequency_a, phase_a,
                  amplitude_b, frequency_b, phase_b, input ready);
  modport sink (input valid, operation, amplitude_a, frequency_a, phase_a,
                amplitude_b, frequency_b, phase_b, output ready);
endinterface

// ===== sv/spa_out_if.sv =====
// ----------------------------------------------------------------------------
// spa_out_if: result channel of the phasor adder
// Valid/ready channel carrying the sum phasor and the mismatch flag.
// ----------------------------------------------------------------------------
interface spa_out_if import spa_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [31:0]                  sum_amplitude;
  logic [31:0]                  sum_frequency;
  logic signed [PHASE_BITS-1:0] sum_phase;
  logic                         freq_mismatch;

  modport source (output valid, sum_amplitude, sum_frequency, sum_phase,
                  freq_mismatch, input ready);
  modport sink (input valid, sum_amplitude, sum_frequency, sum_phase,
                freq_mismatch, output ready);
endinterface

// ===== sv/spa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// spa_cfg_if: configuration write channel
// Valid/ready channel carrying the frequency tolerance.
// ----------------------------------------------------------------------------
interface spa_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/sinusoid_phasor_adder.sv =====
// ----------------------------------------------------------------------------
// sinusoid_phasor_adder: adds or subtracts two sinusoids as phasors
// Normalizes both sinusoids, checks their frequencies, rotates each to x/y
// with a CORDIC, adds the components and vectors the sum back to polar form.
// ----------------------------------------------------------------------------
// The block takes one pair of sinusoids per clock cycle while the output side
// does not stall and returns one result per item, in order. The pipeline
// holds the fully unrolled rotation and vectoring CORDIC stages plus the gain
// multipliers, each split over two registered stages. A stall on the output
// holds every stage in place and drops ready on the input.
module sinusoid_phasor_adder import spa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  spa_in_if.sink    in_ch,
  spa_out_if.source out_ch,
  spa_cfg_if.sink   cfg_ch
);

  localparam int N = CORDIC_STAGES;

  typedef struct packed {
    logic [31:0] amp;
    logic [31:0] freq;
    logic [31:0] z;
  } norm_t;

  // Normalize one sinusoid: magnitudes for amplitude and frequency, phase adjusted to match.
  function automatic norm_t normalize(input logic [31:0] a, input logic [31:0] f,
                                      input logic [PHASE_BITS-1:0] p);
    norm_t n;
    n.z    = {p, {(32-PHASE_BITS){1'b0}}};
    n.freq = f[31] ? (32'd0 - f) : f;
    if (f[31]) n.z = (32'd0 - n.z) + HALF_TURN;
    n.amp  = a[31] ? (32'd0 - a) : a;
    if (a[31]) n.z = n.z + HALF_TURN;
    return n;
  endfunction

  // Low half of the input gain product, rounded: (amp[15:0]*K + 2^15) >> 16.
  function automatic logic [32:0] gain_lo16(input logic [15:0] v);
    logic [48:0] t;
    t = {33'd0, v} * {17'd0, GAIN_Q32} + 49'h8000;
    return t[48:16];
  endfunction

  // Low word of the output gain product, rounded: (lo*K + 2^31) >> 32.
  function automatic logic [32:0] gain_lo32(input logic [31:0] v);
    logic [64:0] t;
    t = {33'd0, v} * {33'd0, GAIN_Q32} + 65'h8000_0000;
    return t[64:32];
  endfunction

  // One rotation-mode iteration.
  function automatic cvec_t rot_step(input cvec_t c, input logic [4:0] sh,
                                     input logic [31:0] atn);
    cvec_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = c.x;
    ys = c.y;
    if (c.z[31]) begin
      r.x = xs + (ys >>> sh);
      r.y = ys - (xs >>> sh);
      r.z = c.z + atn;
    end else begin
      r.x = xs - (ys >>> sh);
      r.y = ys + (xs >>> sh);
      r.z = c.z - atn;
    end
    return r;
  endfunction

  // One vectoring-mode iteration.
  function automatic cvec_t vec_step(input cvec_t c, input logic [4:0] sh,
                                     input logic [31:0] atn);
    cvec_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = c.x;
    ys = c.y;
    if (ys[CW-1]) begin
      r.x = xs - (ys >>> sh);
      r.y = ys + (xs >>> sh);
      r.z = c.z - atn;
    end else begin
      r.x = xs + (ys >>> sh);
      r.y = ys - (xs >>> sh);
      r.z = c.z + atn;
    end
    return r;
  endfunction

  logic en;

  // Configuration register
  logic [15:0] tol_r;

  // Stage 0: normalized sinusoids
  logic        v0_r;
  norm_t       na_r, nb_r;
  norm_t       na_nxt, nb_nxt;

  // Stage 1: frequency check and low gain products
  logic        v1_r;
  side_t       sd1_r;
  logic [31:0] za1_r, zb1_r;
  logic [15:0] ha1_r, hb1_r;
  logic [32:0] la1_r, lb1_r;
  logic [31:0] diff_nxt;

  // Stage 2: gain-compensated start magnitudes
  logic        v2_r;
  side_t       sd2_r;
  logic [31:0] za2_r, zb2_r;
  logic [CW-1:0] xa2_r, xb2_r;
  logic [47:0] pa_nxt, pb_nxt;

  // Rotation CORDIC, entry 0 is the quadrant fold
  logic        rv_r  [0:N];
  side_t       rsd_r [0:N];
  cvec_t       ra_r  [0:N];
  cvec_t       rb_r  [0:N];
  logic [31:0] fza_nxt, fzb_nxt;

  // Vectoring CORDIC, entry 0 is the sum with half-plane fold
  logic        av_r;
  side_t       asd_r;
  logic signed [CW-1:0] sx_r, sy_r;
  logic        vv_r  [0:N];
  side_t       vsd_r [0:N];
  cvec_t       vc_r  [0:N];

  // Output gain multiply, two stages
  logic        m1v_r, m2v_r;
  side_t       m1sd_r, m2sd_r;
  logic [31:0] m1z_r, m2z_r;
  logic [CW-33:0] m1h_r;
  logic [32:0] m1l_r;
  logic [CW-1:0] mag_r;

  // Output register
  logic        ov_r;
  logic [31:0] oamp_r, ofreq_r;
  logic [PHASE_BITS-1:0] oph_r;
  logic        omis_r;
  logic [CW:0] rnd_nxt;
  logic [31:0] ang_nxt;

  // Advance the whole pipeline unless the result is stalled
  assign en          = !ov_r || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  // Hold the tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      av_r  <= 1'b0;
      m1v_r <= 1'b0;
      m2v_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int i = 0; i <= N; i++) begin
        rv_r[i] <= 1'b0;
        vv_r[i] <= 1'b0;
      end
    end else if (en) begin
      v0_r    <= in_ch.valid;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      rv_r[0] <= v2_r;
      for (int i = 0; i < N; i++) begin
        rv_r[i+1] <= rv_r[i];
        vv_r[i+1] <= vv_r[i];
      end
      av_r    <= rv_r[N];
      vv_r[0] <= av_r;
      m1v_r   <= vv_r[N];
      m2v_r   <= m1v_r;
      ov_r    <= m2v_r;
    end
  end

  // Stage 0: normalize, subtract adds a half turn to the second phase
  always_comb begin
    na_nxt = normalize(in_ch.amplitude_a, in_ch.frequency_a, in_ch.phase_a);
    nb_nxt = normalize(in_ch.amplitude_b, in_ch.frequency_b, in_ch.phase_b);
    if (in_ch.operation) nb_nxt.z = nb_nxt.z + HALF_TURN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r <= na_nxt;
      nb_r <= nb_nxt;
    end
  end

  // Stage 1: compare frequencies, start the input gain products
  assign diff_nxt = (na_r.freq > nb_r.freq) ? (na_r.freq - nb_r.freq)
                                            : (nb_r.freq - na_r.freq);

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r.mism <= (diff_nxt > {16'd0, tol_r});
      sd1_r.freq <= na_r.freq;
      sd1_r.zero <= 1'b0;
      za1_r      <= na_r.z;
      zb1_r      <= nb_r.z;
      ha1_r      <= na_r.amp[31:16];
      hb1_r      <= nb_r.amp[31:16];
      la1_r      <= gain_lo16(na_r.amp[15:0]);
      lb1_r      <= gain_lo16(nb_r.amp[15:0]);
    end
  end

  // Stage 2: finish the gain products
  assign pa_nxt = ha1_r * GAIN_Q32;
  assign pb_nxt = hb1_r * GAIN_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r <= sd1_r;
      za2_r <= za1_r;
      zb2_r <= zb1_r;
      xa2_r <= CW'(pa_nxt) + CW'(la1_r);
      xb2_r <= CW'(pb_nxt) + CW'(lb1_r);
    end
  end

  // Fold angles outside the right half plane by a half turn
  assign fza_nxt = za2_r + QUARTER_TURN;
  assign fzb_nxt = zb2_r + QUARTER_TURN;

  always_ff @(posedge clk) begin
    if (en) begin
      rsd_r[0] <= sd2_r;
      ra_r[0].y <= '0;
      rb_r[0].y <= '0;
      if (fza_nxt[31]) begin
        ra_r[0].x <= signed'(CW'(0) - xa2_r);
        ra_r[0].z <= za2_r - HALF_TURN;
      end else begin
        ra_r[0].x <= signed'(xa2_r);
        ra_r[0].z <= za2_r;
      end
      if (fzb_nxt[31]) begin
        rb_r[0].x <= signed'(CW'(0) - xb2_r);
        rb_r[0].z <= zb2_r - HALF_TURN;
      end else begin
        rb_r[0].x <= signed'(xb2_r);
        rb_r[0].z <= zb2_r;
      end
    end
  end

  // Rotation CORDIC stages, one iteration per lane and stage
  for (genvar k = 0; k < N; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        rsd_r[k+1] <= rsd_r[k];
        ra_r[k+1]  <= rot_step(ra_r[k], 5'(k), ATAN_TABLE[k]);
        rb_r[k+1]  <= rot_step(rb_r[k], 5'(k), ATAN_TABLE[k]);
      end
    end
  end

  // Add the components of both lanes
  always_ff @(posedge clk) begin
    if (en) begin
      asd_r <= rsd_r[N];
      sx_r  <= ra_r[N].x + rb_r[N].x;
      sy_r  <= ra_r[N].y + rb_r[N].y;
    end
  end

  // Fold the sum into the right half plane, mark an exactly zero sum
  always_ff @(posedge clk) begin
    if (en) begin
      vsd_r[0] <= '{mism: asd_r.mism, freq: asd_r.freq,
                    zero: (sx_r == '0) && (sy_r == '0)};
      if (sx_r[CW-1]) begin
        vc_r[0].x <= -sx_r;
        vc_r[0].y <= -sy_r;
        vc_r[0].z <= HALF_TURN;
      end else begin
        vc_r[0].x <= sx_r;
        vc_r[0].y <= sy_r;
        vc_r[0].z <= '0;
      end
    end
  end

  // Vectoring CORDIC stages
  for (genvar k = 0; k < N; k++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        vsd_r[k+1] <= vsd_r[k];
        vc_r[k+1]  <= vec_step(vc_r[k], 5'(k), ATAN_TABLE[k]);
      end
    end
  end

  // Output gain: low word first, then high part and sum
  always_ff @(posedge clk) begin
    if (en) begin
      m1sd_r <= vsd_r[N];
      m1z_r  <= vc_r[N].z;
      m1h_r  <= vc_r[N].x[CW-1:32];
      m1l_r  <= gain_lo32(vc_r[N].x[31:0]);
      m2sd_r <= m1sd_r;
      m2z_r  <= m1z_r;
      mag_r  <= CW'(m1h_r * GAIN_Q32) + CW'(m1l_r);
    end
  end

  // Round and saturate the magnitude, round the angle, zero a mismatch result
  assign rnd_nxt = {1'b0, mag_r} + (CW+1)'(32'h8000);
  assign ang_nxt = (m2sd_r.zero ? 32'd0 : m2z_r) + (32'd1 << (31 - PHASE_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      omis_r <= m2sd_r.mism;
      if (m2sd_r.mism) begin
        oamp_r  <= '0;
        ofreq_r <= '0;
        oph_r   <= '0;
      end else begin
        if (m2sd_r.zero) begin
          oamp_r <= '0;
        end else if (|rnd_nxt[CW:48]) begin
          oamp_r <= 32'hFFFF_FFFF;
        end else begin
          oamp_r <= rnd_nxt[47:16];
        end
        ofreq_r <= m2sd_r.freq;
        oph_r   <= ang_nxt[31:32-PHASE_BITS];
      end
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.sum_amplitude = oamp_r;
  assign out_ch.sum_frequency = ofreq_r;
  assign out_ch.sum_phase     = oph_r;
  assign out_ch.freq_mismatch = omis_r;

endmodule

// ===== sv/spa_checker.sv =====
// ----------------------------------------------------------------------------
// spa_checker: port-level checks for the phasor adder
// Watches the result and input handshakes of the top level.
// ----------------------------------------------------------------------------
module spa_checker import spa_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [31:0]           sum_amplitude,
  input logic [31:0]           sum_frequency,
  input logic [PHASE_BITS-1:0] sum_phase,
  input logic                  freq_mismatch
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Drop input ready while the result is stalled
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  // Zero all fields of a mismatch result
  a_mism_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && freq_mismatch |-> sum_amplitude == 32'd0 &&
      sum_frequency == 32'd0 && sum_phase == '0)
    else $error("mismatch result carries data");

  // Keep the frequency a magnitude
  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sum_frequency <= 32'h8000_0000)
    else $error("frequency out of range");

endmodule

bind sinusoid_phasor_adder spa_checker u_spa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .sum_amplitude (out_ch.sum_amplitude),
  .sum_frequency (out_ch.sum_frequency),
  .sum_phase     (out_ch.sum_phase),
  .freq_mismatch (out_ch.freq_mismatch)
);
